// ----- design/intel_hex_record_parser_defines.svh -----
// Assertion macros shared by the Intel HEX record parser sources
`ifndef INTEL_HEX_RECORD_PARSER_DEFINES_SVH
`define INTEL_HEX_RECORD_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define IHEX_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ihex assertion failed");
`define IHEX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ihex assertion failed");
`else
`define IHEX_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define IHEX_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- design/ihex_pkg.sv -----
// Types, codes and helpers of the Intel HEX record parser
`default_nettype none

package ihex_pkg;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    localparam logic [7:0] REC_DATA      = 8'h00;
    localparam logic [7:0] REC_EOF       = 8'h01;
    localparam logic [7:0] REC_EXT_SEG   = 8'h02;
    localparam logic [7:0] REC_START_SEG = 8'h03;
    localparam logic [7:0] REC_EXT_LIN   = 8'h04;
    localparam logic [7:0] REC_START_LIN = 8'h05;

    localparam int IDX_W = 9;
    localparam int TOTAL_W = 24;

    localparam logic [IDX_W-1:0] IDX_LENGTH   = 9'd0;
    localparam logic [IDX_W-1:0] IDX_OFS_HI   = 9'd1;
    localparam logic [IDX_W-1:0] IDX_OFS_LO   = 9'd2;
    localparam logic [IDX_W-1:0] IDX_TYPE     = 9'd3;
    localparam logic [IDX_W-1:0] IDX_DATA     = 9'd4;
    localparam logic [IDX_W-1:0] IDX_MAX      = 9'd511;
    localparam logic [IDX_W-1:0] IDX_OVERHEAD = 9'd5;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFFFFFF;

    typedef enum logic [2:0] {
        KIND_DATA         = 3'd0,
        KIND_ACCEPT       = 3'd1,
        KIND_EOF          = 3'd2,
        KIND_FORMAT_ERR   = 3'd3,
        KIND_CHECKSUM_ERR = 3'd4,
        KIND_UNKNOWN_TYPE = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        PH_AWAIT  = 2'b01,
        PH_RECORD = 2'b10
    } t_phase;

    typedef struct packed {
        t_kind               kind;
        logic [7:0]          data_byte;
        logic [31:0]         address;
        logic [31:0]         start_address;
        logic [TOTAL_W-1:0]  total_bytes;
    } t_result;

    // Non-hex characters decode as zero
    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = 4'(c - 8'h57);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- design/ihex_if.sv -----
// Valid/ready channels for characters in and parse results out
`default_nettype none

interface ihex_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface ihex_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] address;
    logic [31:0] start_address;
    logic [23:0] total_bytes;

    modport source (output valid, output kind, output data_byte, output address,
                    output start_address, output total_bytes, input ready);
    modport sink   (input valid, input kind, input data_byte, input address,
                    input start_address, input total_bytes, output ready);
endinterface

`default_nettype wire

// ----- design/ihex_core.sv -----
// Parser state and per-character decode of the Intel HEX record parser
`default_nettype none
`include "intel_hex_record_parser_defines.svh"

module ihex_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [7:0]        i_char,
    output logic                   o_res_valid,
    output ihex_pkg::t_result      o_res
);
    import ihex_pkg::*;

    t_phase             r_phase, n_phase;
    logic               r_halted, n_halted;
    logic               r_have_hi, n_have_hi;
    logic [3:0]         r_hi, n_hi;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [7:0]         r_len, n_len;
    logic [15:0]        r_offset, n_offset;
    logic [7:0]         r_type, n_type;
    logic [7:0]         r_sum, n_sum;
    logic [15:0]        r_ext, n_ext;
    logic [31:0]        r_upper, n_upper;
    logic [31:0]        r_end, n_end;
    logic [TOTAL_W-1:0] r_total, n_total;

    always_comb begin
        logic [7:0]         b;
        logic [IDX_W-1:0]   d;
        logic [TOTAL_W:0]   sum_total;

        n_phase   = r_phase;
        n_halted  = r_halted;
        n_have_hi = r_have_hi;
        n_hi      = r_hi;
        n_idx     = r_idx;
        n_len     = r_len;
        n_offset  = r_offset;
        n_type    = r_type;
        n_sum     = r_sum;
        n_ext     = r_ext;
        n_upper   = r_upper;
        n_end     = r_end;
        n_total   = r_total;
        o_res_valid = 1'b0;
        o_res       = '0;

        b = {r_hi, hex_nibble(i_char)};
        d = r_idx - IDX_DATA;
        sum_total = {1'b0, r_total} + {{(TOTAL_W-7){1'b0}}, r_len};

        if (i_step && !r_halted && i_char != CHAR_CR) begin
            if (r_phase == PH_AWAIT) begin
                if (i_char != CHAR_COLON) begin
                    n_halted    = 1'b1;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_FORMAT_ERR;
                end else begin
                    n_phase   = PH_RECORD;
                    n_have_hi = 1'b0;
                    n_hi      = 4'd0;
                    n_idx     = '0;
                    n_len     = 8'd0;
                    n_offset  = 16'd0;
                    n_type    = 8'd0;
                    n_sum     = 8'd0;
                    n_ext     = 16'd0;
                end
            end else if (i_char == CHAR_LF) begin
                n_phase     = PH_AWAIT;
                o_res_valid = 1'b1;
                if (r_have_hi || r_idx != ({1'b0, r_len} + IDX_OVERHEAD)) begin
                    n_halted   = 1'b1;
                    o_res.kind = KIND_FORMAT_ERR;
                end else if (r_sum != 8'd0) begin
                    n_halted   = 1'b1;
                    o_res.kind = KIND_CHECKSUM_ERR;
                end else begin
                    o_res.kind      = KIND_ACCEPT;
                    o_res.data_byte = r_type;
                    case (r_type)
                        REC_DATA: begin
                            n_total = sum_total[TOTAL_W] ? TOTAL_MAX
                                                         : sum_total[TOTAL_W-1:0];
                            if (r_len != 8'd0) begin
                                n_end = r_upper + {16'd0, r_offset} + {24'd0, r_len}
                                        - 32'd1;
                            end
                        end
                        REC_EOF: begin
                            o_res.kind          = KIND_EOF;
                            o_res.data_byte     = 8'd0;
                            o_res.address       = r_end;
                            o_res.start_address = r_end + 32'd1
                                                  - {{(32-TOTAL_W){1'b0}}, r_total};
                            o_res.total_bytes   = r_total;
                        end
                        REC_EXT_SEG:   n_upper = {12'd0, r_ext, 4'd0};
                        REC_EXT_LIN:   n_upper = {r_ext, 16'd0};
                        REC_START_SEG, REC_START_LIN: begin
                            // accepted, no effect
                        end
                        default: begin
                            n_halted        = 1'b1;
                            o_res.kind      = KIND_UNKNOWN_TYPE;
                            o_res.data_byte = 8'd0;
                        end
                    endcase
                end
            end else if (!r_have_hi) begin
                n_hi      = hex_nibble(i_char);
                n_have_hi = 1'b1;
            end else begin
                n_have_hi = 1'b0;
                n_sum     = r_sum + b;
                n_idx     = (r_idx < IDX_MAX) ? r_idx + 9'd1 : IDX_MAX;
                case (r_idx)
                    IDX_LENGTH: n_len = b;
                    IDX_OFS_HI: n_offset = {b, r_offset[7:0]};
                    IDX_OFS_LO: n_offset = {r_offset[15:8], b};
                    IDX_TYPE:   n_type = b;
                    default: begin
                        if (d < {1'b0, r_len}) begin
                            if (d == 9'd0) begin
                                n_ext = {b, r_ext[7:0]};
                            end else if (d == 9'd1) begin
                                n_ext = {r_ext[15:8], b};
                            end
                            if (r_type == REC_DATA) begin
                                o_res_valid     = 1'b1;
                                o_res.kind      = KIND_DATA;
                                o_res.data_byte = b;
                                o_res.address   = r_upper + {16'd0, r_offset}
                                                  + {23'd0, d};
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_AWAIT;
            r_halted  <= 1'b0;
            r_have_hi <= 1'b0;
            r_hi      <= 4'd0;
            r_idx     <= '0;
            r_len     <= 8'd0;
            r_offset  <= 16'd0;
            r_type    <= 8'd0;
            r_sum     <= 8'd0;
            r_ext     <= 16'd0;
            r_upper   <= 32'd0;
            r_end     <= 32'd0;
            r_total   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_halted  <= n_halted;
            r_have_hi <= n_have_hi;
            r_hi      <= n_hi;
            r_idx     <= n_idx;
            r_len     <= n_len;
            r_offset  <= n_offset;
            r_type    <= n_type;
            r_sum     <= n_sum;
            r_ext     <= n_ext;
            r_upper   <= n_upper;
            r_end     <= n_end;
            r_total   <= n_total;
        end
    end

    // a halted parser stays silent
    `IHEX_ASSERT_IMPL(a_halt_silent, i_clk, i_rst_n, r_halted, !o_res_valid)
    // every error report halts the parser
    `IHEX_ASSERT_NEXT(a_err_halts, i_clk, i_rst_n,
        o_res_valid && (o_res.kind == KIND_FORMAT_ERR || o_res.kind == KIND_CHECKSUM_ERR
                        || o_res.kind == KIND_UNKNOWN_TYPE),
        r_halted)
    // between records no half byte is pending unless halted
    `IHEX_ASSERT_IMPL(a_await_clean, i_clk, i_rst_n,
        r_phase == PH_AWAIT && !r_halted, !r_have_hi)

endmodule

`default_nettype wire

// ----- design/intel_hex_record_parser.sv -----
// Intel HEX record parser: input register, parser core, result register
// A character taken into the input register is decoded into the result register.
// Throughput: one character per cycle unless the output stalls; while a result
//   word waits, one character is still taken and held in the input register.
// Reset (i_rst_n low, synchronous): clears the parser, the address state and
//   empties both registers. An error halts the parser until the next reset.
`default_nettype none
`include "intel_hex_record_parser_defines.svh"

module intel_hex_record_parser (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    ihex_char_if.sink     i_char,
    ihex_result_if.source o_result
);
    import ihex_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_out_valid;
    t_result    r_out;

    logic       step;
    logic       res_valid;
    t_result    res;

    // advance the input word when the result register is free or draining
    assign step = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_char.ready = !r_in_valid || step;

    ihex_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_char      (r_char),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_char.valid && i_char.ready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= res_valid;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_char <= i_char.char_in;
        end
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.kind          = r_out.kind;
    assign o_result.data_byte     = r_out.data_byte;
    assign o_result.address       = r_out.address;
    assign o_result.start_address = r_out.start_address;
    assign o_result.total_bytes   = r_out.total_bytes;

    // a held input word blocks new characters
    `IHEX_ASSERT_IMPL(a_in_hold, i_clk, i_rst_n, r_in_valid && !step, !i_char.ready)
    // a result word that is stalled survives to the next cycle
    `IHEX_ASSERT_NEXT(a_out_keep, i_clk, i_rst_n, r_out_valid && !o_result.ready,
        r_out_valid)
    // a stalled result word holds its fields
    `IHEX_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, r_out_valid && !o_result.ready,
        $stable(r_out))

endmodule

`default_nettype wire
